// File: rtl/core/sitda_pkg.sv
// sitda_pkg: shared constants and helper functions for the signed integer
// to decimal ASCII unit. No dependencies.
`default_nettype none
package sitda_pkg;

  localparam int VALUE_BITS_DEF = 16;
  localparam int CHAR_W         = 6;

  localparam logic [CHAR_W-1:0] CHAR_MINUS = 6'd45;
  localparam logic [CHAR_W-1:0] CHAR_ZERO  = 6'd48;

  // decimal digits needed for the largest magnitude, 2**(bits-1)
  function automatic int digits_for(input int bits);
    longint unsigned m;
    int n;
    m = longint'(1) << (bits - 1);
    n = 1;
    for (int i = 0; i < 20; i++) begin
      if (m >= 10) begin
        m = m / 10;
        n = n + 1;
      end
    end
    return n;
  endfunction

endpackage
`default_nettype wire

// File: rtl/core/signed_int_to_decimal_ascii_unit.sv
// signed_int_to_decimal_ascii_unit: top level, sequencer around the shared
// double-dabble step. Depends on sitda_pkg and sitda_dabble.
//
// Accepts one signed VALUE_BITS integer when start is high and busy is low,
// then emits its decimal text most significant character first: an optional
// '-', then the digits without leading zeros. Each word has out_valid high for
// one cycle and appears the cycle after the sequencer produces it. The digits
// come in consecutive cycles, out_last marks the final digit, and the '-' is never
// followed directly by the first digit. The receiver cannot stall.
// While busy, the sequencer runs the shift-add-3 step once per input bit, then
// skips the leading zeros one at a time, leaves the skip and emits the digits
// one at a time, with a step for the minus sign on a negative value. The last
// digit is on the ports in the first cycle with busy low.
`default_nettype none
module signed_int_to_decimal_ascii_unit #(
  parameter int VALUE_BITS = sitda_pkg::VALUE_BITS_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          start,
  output logic                               busy,
  input  wire logic signed [VALUE_BITS-1:0]  in_value,
  output logic                               out_valid,
  output logic        [sitda_pkg::CHAR_W-1:0] out_character,
  output logic                               out_last
);

  localparam int NUM_DIGITS = sitda_pkg::digits_for(VALUE_BITS);
  localparam int BCD_W      = 4 * NUM_DIGITS;
  localparam int CNT_W      = $clog2(VALUE_BITS + 1);
  localparam int IDX_W      = $clog2(NUM_DIGITS + 1);
  localparam int CW         = sitda_pkg::CHAR_W;

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_CONV = 3'd1;
  localparam logic [2:0] ST_SIGN = 3'd2;
  localparam logic [2:0] ST_SKIP = 3'd3;
  localparam logic [2:0] ST_EMIT = 3'd4;

  logic [2:0]            state_r, state_nxt;
  logic                  neg_r, neg_nxt;
  logic [VALUE_BITS-1:0] mag_r, mag_nxt;
  logic [BCD_W-1:0]      bcd_r, bcd_nxt;
  logic [CNT_W-1:0]      cnt_r, cnt_nxt;
  logic [IDX_W-1:0]      idx_r, idx_nxt;
  logic                  out_valid_r, out_valid_nxt;
  logic [CW-1:0]         out_char_r, out_char_nxt;
  logic                  out_last_r, out_last_nxt;

  logic [BCD_W-1:0]      step_bcd;
  logic [3:0]            top_digit;

  sitda_dabble #(
    .NUM_DIGITS(NUM_DIGITS)
  ) u_dabble (
    .bcd_i(bcd_r),
    .bit_i(mag_r[VALUE_BITS-1]),
    .bcd_o(step_bcd)
  );

  assign top_digit = bcd_r[BCD_W-1 -: 4];

  always_comb begin
    state_nxt     = state_r;
    neg_nxt       = neg_r;
    mag_nxt       = mag_r;
    bcd_nxt       = bcd_r;
    cnt_nxt       = cnt_r;
    idx_nxt       = idx_r;
    out_valid_nxt = 1'b0;
    out_char_nxt  = out_char_r;
    out_last_nxt  = out_last_r;
    unique case (state_r)
      ST_IDLE: begin
        if (start) begin
          neg_nxt   = in_value[VALUE_BITS-1];
          mag_nxt   = in_value[VALUE_BITS-1] ? (~in_value + 1'b1) : in_value;
          bcd_nxt   = '0;
          cnt_nxt   = CNT_W'(VALUE_BITS);
          state_nxt = ST_CONV;
        end
      end
      ST_CONV: begin
        bcd_nxt = step_bcd;
        mag_nxt = {mag_r[VALUE_BITS-2:0], 1'b0};
        cnt_nxt = cnt_r - 1'b1;
        idx_nxt = IDX_W'(NUM_DIGITS);
        if (cnt_r == CNT_W'(1)) begin
          state_nxt = neg_r ? ST_SIGN : ST_SKIP;
        end
      end
      ST_SIGN: begin
        out_valid_nxt = 1'b1;
        out_char_nxt  = sitda_pkg::CHAR_MINUS;
        out_last_nxt  = 1'b0;
        state_nxt     = ST_SKIP;
      end
      ST_SKIP: begin
        if (top_digit == 4'd0 && idx_r > IDX_W'(1)) begin
          bcd_nxt = {bcd_r[BCD_W-5:0], 4'd0};
          idx_nxt = idx_r - 1'b1;
        end else begin
          state_nxt = ST_EMIT;
        end
      end
      ST_EMIT: begin
        out_valid_nxt = 1'b1;
        out_char_nxt  = sitda_pkg::CHAR_ZERO + {{(CW-4){1'b0}}, top_digit};
        out_last_nxt  = (idx_r == IDX_W'(1));
        bcd_nxt       = {bcd_r[BCD_W-5:0], 4'd0};
        idx_nxt       = idx_r - 1'b1;
        if (idx_r == IDX_W'(1)) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    neg_r      <= neg_nxt;
    mag_r      <= mag_nxt;
    bcd_r      <= bcd_nxt;
    cnt_r      <= cnt_nxt;
    idx_r      <= idx_nxt;
    out_char_r <= out_char_nxt;
    out_last_r <= out_last_nxt;
  end

  assign busy          = (state_r != ST_IDLE);
  assign out_valid     = out_valid_r;
  assign out_character = out_char_r;
  assign out_last      = out_last_r;

`ifndef ASSERT_OFF
  a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> busy)
    else $error("accepted word did not raise busy");

  a_last_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_last |-> !busy)
    else $error("still busy after last character");

  a_char_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_character == sitda_pkg::CHAR_MINUS) ||
                  (out_character >= sitda_pkg::CHAR_ZERO &&
                   out_character <= sitda_pkg::CHAR_ZERO + CW'(9)))
    else $error("character out of range");

  a_minus_not_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_character == sitda_pkg::CHAR_MINUS |-> !out_last)
    else $error("minus sign flagged last");
`endif

endmodule
`default_nettype wire

// File: rtl/core/sitda_dabble.sv
// sitda_dabble: one shift-and-add-3 step of binary to BCD conversion.
// Depends on nothing but its parameter.
`default_nettype none
module sitda_dabble #(
  parameter int NUM_DIGITS = 5
) (
  input  wire logic [4*NUM_DIGITS-1:0] bcd_i,
  input  wire logic                    bit_i,
  output logic      [4*NUM_DIGITS-1:0] bcd_o
);

  logic [4*NUM_DIGITS-1:0] adj;

  always_comb begin
    for (int d = 0; d < NUM_DIGITS; d++) begin
      if (bcd_i[4*d +: 4] >= 4'd5) begin
        adj[4*d +: 4] = bcd_i[4*d +: 4] + 4'd3;
      end else begin
        adj[4*d +: 4] = bcd_i[4*d +: 4];
      end
    end
  end

  assign bcd_o = {adj[4*NUM_DIGITS-2:0], bit_i};

endmodule
`default_nettype wire
